FILE: src/chs_pkg.sv
// Package for the chained hash set core: status codes, widths and result type.
// Used by every module under src but chs_queue; depends on nothing.
package chs_pkg;

	localparam int unsigned BUCKETS_DEF  = 64;
	localparam int unsigned NODES_DEF    = 256;
	localparam int unsigned KEY_BITS_DEF = 64;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned ENTRY_W  = 8;
	localparam int unsigned BKT_W    = 6;
	localparam int unsigned COUNT_W  = 7;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  entry_index;
		logic [BKT_W-1:0]    bucket_index;
		logic                collided;
		logic [COUNT_W-1:0]  buckets_in_use;
	} result_t;

endpackage

FILE: src/chs_front.sv
// Front end of the chained hash set: accepts operations, checks the key and the
// bucket count, and reduces the key modulo the count one bit a cycle. Uses chs_pkg.
module chs_front #(
	parameter int unsigned BUCKETS  = chs_pkg::BUCKETS_DEF,
	parameter int unsigned KEY_BITS = chs_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic [chs_pkg::KEY_W-1:0]   in_key,
	input  logic [chs_pkg::SIZE_W-1:0]  bkt_count,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output logic                        cmd_op,
	output logic [KEY_BITS-1:0]         cmd_key,
	output logic [chs_pkg::STATUS_W-1:0] cmd_status,
	output logic [chs_pkg::SIZE_W-1:0]  cmd_bucket
);

	localparam int unsigned CNT_W = $clog2(KEY_BITS + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_OUT  = 3'b100
	} fstate_t;

	fstate_t                    state_q;
	logic [KEY_BITS-1:0]        key_q;
	logic [KEY_BITS-1:0]        shift_q;
	logic [chs_pkg::SIZE_W:0]   rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       op_q;
	logic [chs_pkg::STATUS_W-1:0] status_q;
	logic [chs_pkg::SIZE_W:0]   rem_sh;
	logic [KEY_BITS-1:0]        key_m;
	logic                       bad_size;

	assign key_m    = in_key[KEY_BITS-1:0];
	assign bad_size = (bkt_count == '0) ||
		({{(32-chs_pkg::SIZE_W){1'b0}}, bkt_count} > BUCKETS);
	assign rem_sh   = {rem_q[chs_pkg::SIZE_W-1:0], shift_q[KEY_BITS-1]};

	assign in_ready   = (state_q == F_IDLE);
	assign cmd_valid  = (state_q == F_OUT);
	assign cmd_op     = op_q;
	assign cmd_key    = key_q;
	assign cmd_status = status_q;
	assign cmd_bucket = rem_q[chs_pkg::SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) begin
					if (key_m == '0 || bad_size)
						state_q <= F_OUT;
					else
						state_q <= F_DIV;
				end
				F_DIV: if (cnt_q == CNT_W'(KEY_BITS - 1)) state_q <= F_OUT;
				F_OUT: if (cmd_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Restoring division; bkt_count must stay stable in flight, unenforced.
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				op_q    <= in_op;
				key_q   <= key_m;
				shift_q <= key_m;
				rem_q   <= '0;
				cnt_q   <= '0;
				if (key_m == '0)
					status_q <= chs_pkg::ST_ZERO_KEY;
				else if (bad_size)
					status_q <= chs_pkg::ST_BAD_SIZE;
				else
					status_q <= chs_pkg::ST_OK;
			end
			F_DIV: begin
				shift_q <= shift_q << 1;
				cnt_q   <= cnt_q + 1'b1;
				if (rem_sh >= {1'b0, bkt_count})
					rem_q <= rem_sh - {1'b0, bkt_count};
				else
					rem_q <= rem_sh;
			end
			default: ;
		endcase
	end

endmodule

FILE: src/chs_queue.sv
// Two-entry command queue between the front and back ends of the hash set.
// Does not use chs_pkg; its width is set through the parameter WIDTH.
module chs_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

endmodule

FILE: src/chs_back.sv
// Back end of the hash set: head table, node pool, chain walker and result register.
// Uses chs_pkg for status codes and the result type.
module chs_back #(
	parameter int unsigned BUCKETS  = chs_pkg::BUCKETS_DEF,
	parameter int unsigned NODES    = chs_pkg::NODES_DEF,
	parameter int unsigned KEY_BITS = chs_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_clear,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic                         cmd_op,
	input  logic [KEY_BITS-1:0]          cmd_key,
	input  logic [chs_pkg::STATUS_W-1:0] cmd_status,
	input  logic [chs_pkg::SIZE_W-1:0]   cmd_bucket,
	output logic                         res_valid,
	input  logic                         res_ready,
	output chs_pkg::result_t             res
);

	localparam int unsigned BI_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned NI_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned NU_W  = $clog2(NODES + 1);
	localparam int unsigned OC_W  = $clog2(BUCKETS + 1);

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_HEAD  = 6'b000010,
		B_RD    = 6'b000100,
		B_CHK   = 6'b001000,
		B_DONE  = 6'b010000,
		B_OUT   = 6'b100000
	} bstate_t;

	bstate_t                state_q;
	logic [BUCKETS-1:0]     hvalid_q;
	logic [NI_W-1:0]        head_q [BUCKETS];
	logic [KEY_BITS-1:0]    keys_q [NODES];
	logic [NI_W:0]          next_q [NODES];
	logic [NU_W-1:0]        used_q;
	logic [OC_W-1:0]        occ_q;

	logic                   op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [BI_W-1:0]        bkt_q;
	logic [NI_W-1:0]        cur_q;
	logic [KEY_BITS-1:0]    rkey_q;
	logic [NI_W:0]          rnext_q;
	logic [NU_W-1:0]        steps_q;
	logic [chs_pkg::STATUS_W-1:0] st_q;
	logic [NI_W-1:0]        ent_q;
	logic                   coll_q;
	logic [chs_pkg::SIZE_W-1:0] bout_q;

	logic                   wr_node;
	logic                   link_en;
	logic [NI_W-1:0]        new_n;

	assign cmd_ready = (state_q == B_IDLE);
	assign res_valid = (state_q == B_OUT);
	assign new_n     = used_q[NI_W-1:0];

	assign res.status         = st_q;
	assign res.entry_index    = chs_pkg::ENTRY_W'(ent_q);
	assign res.bucket_index   = bout_q[chs_pkg::BKT_W-1:0];
	assign res.collided       = coll_q;
	assign res.buckets_in_use = chs_pkg::COUNT_W'(occ_q);

	// The new node is written in the cycle that finds the tail; the tail is linked
	// to it in the next cycle, in B_DONE, since the link memory has a single write port.
	assign wr_node = (state_q == B_HEAD) && !op_q && hvalid_q[bkt_q] == 1'b0;
	assign link_en = (state_q == B_CHK) && !op_q &&
		(!rnext_q[NI_W] || steps_q == NU_W'(NODES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			hvalid_q <= '0;
			used_q   <= '0;
			occ_q    <= '0;
		end else begin
			if (cfg_clear) begin
				hvalid_q <= '0;
				occ_q    <= '0;
			end
			unique case (state_q)
				B_IDLE: if (cmd_valid) begin
					if (cmd_status != chs_pkg::ST_OK)
						state_q <= B_OUT;
					else if (!cmd_op && used_q >= NU_W'(NODES))
						state_q <= B_OUT;
					else
						state_q <= B_HEAD;
				end
				B_HEAD: begin
					if (!hvalid_q[bkt_q]) begin
						state_q <= B_OUT;
						if (!op_q) begin
							hvalid_q[bkt_q] <= 1'b1;
							occ_q <= occ_q + 1'b1;
							used_q <= used_q + 1'b1;
						end
					end else begin
						state_q <= B_RD;
					end
				end
				B_RD: state_q <= B_CHK;
				B_CHK: begin
					if (op_q) begin
						if (rkey_q == key_q || !rnext_q[NI_W] || steps_q == NU_W'(NODES))
							state_q <= B_OUT;
						else
							state_q <= B_RD;
					end else if (link_en) begin
						state_q <= B_DONE;
						used_q  <= used_q + 1'b1;
					end else begin
						state_q <= B_RD;
					end
				end
				B_DONE: state_q <= B_OUT;
				B_OUT: if (res_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Head table writes.
	always_ff @(posedge clk) begin
		if (wr_node) head_q[bkt_q] <= new_n;
	end

	// Node pool: key and link memories, one write port each, registered read.
	always_ff @(posedge clk) begin
		if ((state_q == B_HEAD && !op_q && !hvalid_q[bkt_q]) || link_en)
			keys_q[new_n] <= key_q;
		if (state_q == B_RD) rkey_q <= keys_q[cur_q];
	end

	always_ff @(posedge clk) begin
		if ((state_q == B_HEAD && !op_q && !hvalid_q[bkt_q]) || link_en)
			next_q[new_n] <= '0;
		else if (state_q == B_DONE)
			next_q[cur_q] <= {1'b1, ent_q};
		if (state_q == B_RD) rnext_q <= next_q[cur_q];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				op_q    <= cmd_op;
				key_q   <= cmd_key;
				bkt_q   <= BI_W'(cmd_bucket);
				steps_q <= '0;
				coll_q  <= 1'b0;
				ent_q   <= '0;
				if (cmd_status == chs_pkg::ST_ZERO_KEY ||
						cmd_status == chs_pkg::ST_BAD_SIZE) begin
					st_q   <= cmd_status;
					bout_q <= '0;
				end else begin
					bout_q <= cmd_bucket;
					if (!cmd_op && used_q >= NU_W'(NODES))
						st_q <= chs_pkg::ST_POOL_FULL;
					else
						st_q <= chs_pkg::ST_OK;
				end
			end
			B_HEAD: begin
				cur_q <= head_q[bkt_q];
				if (!hvalid_q[bkt_q]) begin
					if (op_q) st_q <= chs_pkg::ST_NOT_FOUND;
					else      ent_q <= new_n;
				end
			end
			B_CHK: begin
				steps_q <= steps_q + 1'b1;
				if (op_q) begin
					if (rkey_q == key_q) begin
						ent_q <= cur_q;
					end else if (!rnext_q[NI_W] || steps_q == NU_W'(NODES)) begin
						st_q <= chs_pkg::ST_NOT_FOUND;
					end else begin
						cur_q <= rnext_q[NI_W-1:0];
					end
				end else if (link_en) begin
					ent_q  <= new_n;
					coll_q <= 1'b1;
				end else begin
					cur_q <= rnext_q[NI_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: src/chained_hash_set_insert_find_core.sv
// Chained hash set core. An operation passes through the bit-serial modulo front end, a
// two-entry queue and the back end's chain walk; a zero key or a bad bucket count is rejected
// early, without the modulo. The front end takes a new operation only once it has handed
// the last one to the queue; the queue lets the back end's chain walk overlap the next modulo.
// Reset (arst_n low, asynchronous) empties every bucket, the pool and the queue; 64 buckets.
module chained_hash_set_insert_find_core #(
	parameter int unsigned BUCKETS  = chs_pkg::BUCKETS_DEF,
	parameter int unsigned NODES    = chs_pkg::NODES_DEF,
	parameter int unsigned KEY_BITS = chs_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: the bucket count.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,   // [6:0] bucket count
	// Operation stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata, // [63:0] key
	input  logic        s_axis_tuser, // [0] op
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata  // [2:0] status, [10:3] entry_index,
	                                  // [16:11] bucket_index, [17] collided,
	                                  // [24:18] buckets_in_use, top bits zero
);

	localparam int unsigned QW = 1 + KEY_BITS + chs_pkg::STATUS_W + chs_pkg::SIZE_W;

	logic [chs_pkg::SIZE_W-1:0]   size_q;
	logic                         f_valid;
	logic                         f_ready;
	logic                         f_op;
	logic [KEY_BITS-1:0]          f_key;
	logic [chs_pkg::STATUS_W-1:0] f_status;
	logic [chs_pkg::SIZE_W-1:0]   f_bucket;
	logic [QW-1:0]                q_in;
	logic [QW-1:0]                q_out;
	logic                         q_valid;
	logic                         q_ready;
	chs_pkg::result_t             res;
	logic                         cfg_fire;

	// Writes are to be made only while idle; the block does not enforce it and takes every write.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= chs_pkg::SIZE_W'(64);
		else if (cfg_fire) size_q <= cfg_data[chs_pkg::SIZE_W-1:0];
	end

	chs_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
		.clk, .arst_n,
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_key    (s_axis_tdata),
		.bkt_count (size_q),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_op    (f_op),
		.cmd_key   (f_key),
		.cmd_status(f_status),
		.cmd_bucket(f_bucket)
	);

	assign q_in = {f_op, f_key, f_status, f_bucket};

	chs_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(q_in),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
	);

	chs_back #(.BUCKETS(BUCKETS), .NODES(NODES), .KEY_BITS(KEY_BITS)) u_back (
		.clk, .arst_n,
		.cfg_clear (cfg_fire),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd_op    (q_out[QW-1]),
		.cmd_key   (q_out[QW-2 -: KEY_BITS]),
		.cmd_status(q_out[chs_pkg::SIZE_W +: chs_pkg::STATUS_W]),
		.cmd_bucket(q_out[chs_pkg::SIZE_W-1:0]),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res
	);

	// Status in the lowest bits, buckets_in_use above the other fields, zeros on top.
	assign m_axis_tdata = {7'd0, res.buckets_in_use, res.collided, res.bucket_index,
		res.entry_index, res.status};

endmodule

FILE: sim/tb_top.sv
// Testbench for the chained hash set core: directed table, then random insert and find traffic.
// A predictor of the hash set checks every result transfer.
// Depends on src/chs_pkg.sv and src/chained_hash_set_insert_find_core.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;
	localparam int   TSIZE_RESET = 64;
	localparam int   SETTLE = 700;          // worst chain walk plus the modulo front end
	localparam longint LIMIT = 6000000;     // cycle limit for the whole run
	localparam int   N_RANDOM = 1130;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	chained_hash_set_insert_find_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the hash set. Node contents are only read for allocated nodes.
	logic [6:0]  tsize;
	logic        head_vld [64];
	logic [8:0]  head_at  [64];
	logic [63:0] node_key [256];
	logic        link_vld [256];
	logic [8:0]  link_at  [256];
	int unsigned pool_used;
	int unsigned occupied;
	logic [63:0] live_keys [$];       // keys inserted since the last size write

	chs_pkg::result_t pending_results [$];
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned pool_full_seen = 0;
	longint cycles = 0;

	// Idling percentages for each side, and the long receiver hold-off.
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	logic hold_go = 1'b0;
	logic hold_taken = 1'b0;
	int unsigned hold_left = 0;

	function automatic void clear_heads();
		for (int b = 0; b < 64; b++) begin
			head_vld[b] = 1'b0;
			head_at[b] = '0;
		end
		occupied = 0;
		live_keys.delete();
	endfunction

	// Works out the result of one operation and applies it to the shadow state.
	function automatic chs_pkg::result_t hash_set_apply(logic op, logic [63:0] key);
		chs_pkg::result_t r;
		int unsigned b;
		int unsigned cur;
		int unsigned n;
		int unsigned steps;
		logic cv;
		r = '0;
		if (key == 64'd0) begin
			r.status = chs_pkg::ST_ZERO_KEY;
		end else if (tsize == 0 || tsize > 64) begin
			r.status = chs_pkg::ST_BAD_SIZE;
		end else begin
			b = int'(key % 64'(tsize));
			r.bucket_index = b[5:0];
			if (op == OP_INSERT) begin
				if (pool_used >= 256) begin
					r.status = chs_pkg::ST_POOL_FULL;
				end else begin
					n = pool_used;
					pool_used++;
					node_key[n] = key;
					link_vld[n] = 1'b0;
					link_at[n] = '0;
					live_keys.push_back(key);
					if (!head_vld[b]) begin
						head_vld[b] = 1'b1;
						head_at[b] = 9'(n);
						occupied++;
					end else begin
						// Append at the tail of the chain.
						cur = head_at[b] % 256;
						steps = 0;
						while (link_vld[cur] && steps < 256) begin
							cur = link_at[cur] % 256;
							steps++;
						end
						link_vld[cur] = 1'b1;
						link_at[cur] = 9'(n);
						r.collided = 1'b1;
					end
					r.status = chs_pkg::ST_OK;
					r.entry_index = n[7:0];
				end
			end else begin
				r.status = chs_pkg::ST_NOT_FOUND;
				cv = head_vld[b];
				cur = head_at[b] % 256;
				steps = 0;
				while (cv && steps < 256) begin
					if (node_key[cur] == key) begin
						r.status = chs_pkg::ST_OK;
						r.entry_index = cur[7:0];
						break;
					end
					cv = link_vld[cur];
					cur = link_at[cur] % 256;
					steps++;
				end
			end
		end
		r.buckets_in_use = occupied[6:0];
		return r;
	endfunction

	// Offers one operation, with a random gap first, and records its expected result.
	task automatic send_op(logic op, logic [63:0] key, logic has_typed,
			chs_pkg::result_t typed);
		chs_pkg::result_t r;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = hash_set_apply(op, key);
		if (has_typed) r = typed;
		pending_results.push_back(r);
	endtask

	// Writes the bucket count once the core has gone idle.
	task automatic write_size(logic [7:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tsize = value[6:0];
		clear_heads();
	endtask

	// Receiver: random back-pressure, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= 3000;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Every result transfer is compared with the oldest expectation, field by field.
	always @(posedge clk) begin
		logic [31:0] word;
		chs_pkg::result_t got;
		chs_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			word = m_axis_tdata;
			got.status = word[2:0];
			got.entry_index = word[10:3];
			got.bucket_index = word[16:11];
			got.collided = word[17];
			got.buckets_in_use = word[24:18];
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (want.status == chs_pkg::ST_POOL_FULL) pool_full_seen++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_count++;
				end
				if (got.entry_index !== want.entry_index) begin
					$error("entry_index: expected %0d, got %0d",
						want.entry_index, got.entry_index);
					fail_count++;
				end
				if (got.bucket_index !== want.bucket_index) begin
					$error("bucket_index: expected %0d, got %0d",
						want.bucket_index, got.bucket_index);
					fail_count++;
				end
				if (got.collided !== want.collided) begin
					$error("collided: expected %0d, got %0d", want.collided, got.collided);
					fail_count++;
				end
				if (got.buckets_in_use !== want.buckets_in_use) begin
					$error("buckets_in_use: expected %0d, got %0d",
						want.buckets_in_use, got.buckets_in_use);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("chained_hash_set_insert_find_core verification failed");
			$finish;
		end
	end

	typedef struct {
		logic        is_cfg;
		logic [7:0]  cfg_value;
		logic        op;
		logic [63:0] key;
		logic        has_typed;
		chs_pkg::result_t typed;
	} stim_row_t;

	function automatic chs_pkg::result_t res(logic [2:0] st, int e, int b, logic c, int u);
		chs_pkg::result_t r;
		r.status = st;
		r.entry_index = e[7:0];
		r.bucket_index = b[5:0];
		r.collided = c;
		r.buckets_in_use = u[6:0];
		return r;
	endfunction

	initial begin
		stim_row_t rows [$];
		logic op;
		logic [63:0] key;
		int unsigned pick;
		int unsigned waited;
		tsize = TSIZE_RESET[6:0];
		pool_used = 0;
		clear_heads();

		// Directed part. After reset the table has 64 buckets, so 5 and 69 share bucket 5.
		rows.push_back('{0, 0, OP_INSERT, 64'd5, 1, res(chs_pkg::ST_OK, 0, 5, 0, 1)});
		rows.push_back('{0, 0, OP_INSERT, 64'd69, 1, res(chs_pkg::ST_OK, 1, 5, 1, 1)});
		rows.push_back('{0, 0, OP_FIND, 64'd69, 1, res(chs_pkg::ST_OK, 1, 5, 0, 1)});
		rows.push_back('{0, 0, OP_FIND, 64'd133, 1,
			res(chs_pkg::ST_NOT_FOUND, 0, 5, 0, 1)});
		rows.push_back('{0, 0, OP_INSERT, 64'd0, 1, res(chs_pkg::ST_ZERO_KEY, 0, 0, 0, 1)});
		rows.push_back('{0, 0, OP_FIND, 64'd0, 1, res(chs_pkg::ST_ZERO_KEY, 0, 0, 0, 1)});
		rows.push_back('{0, 0, OP_INSERT, '1, 0, '0});
		rows.push_back('{0, 0, OP_FIND, '1, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'd64, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'd5, 0, '0});   // duplicate key is kept
		rows.push_back('{0, 0, OP_FIND, 64'd5, 0, '0});
		// A size of zero is invalid; the zero-key check still wins.
		rows.push_back('{1, 8'd0, 0, 0, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'd7, 1, res(chs_pkg::ST_BAD_SIZE, 0, 0, 0, 0)});
		rows.push_back('{0, 0, OP_FIND, 64'd7, 1, res(chs_pkg::ST_BAD_SIZE, 0, 0, 0, 0)});
		rows.push_back('{0, 0, OP_INSERT, 64'd0, 1, res(chs_pkg::ST_ZERO_KEY, 0, 0, 0, 0)});
		// Sizes above the bucket count are invalid too; bit 7 of the data is dropped.
		rows.push_back('{1, 8'hFF, 0, 0, 0, '0});
		rows.push_back('{0, 0, OP_FIND, 64'd9, 1, res(chs_pkg::ST_BAD_SIZE, 0, 0, 0, 0)});
		rows.push_back('{1, 8'd65, 0, 0, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'd3, 1, res(chs_pkg::ST_BAD_SIZE, 0, 0, 0, 0)});
		// One bucket: everything chains; earlier nodes are no longer reachable.
		rows.push_back('{1, 8'd1, 0, 0, 0, '0});
		rows.push_back('{0, 0, OP_FIND, 64'd5, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'd123, 0, '0});
		rows.push_back('{0, 0, OP_INSERT, 64'h8000_0000_0000_0000, 0, '0});
		rows.push_back('{0, 0, OP_FIND, 64'h8000_0000_0000_0000, 0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_size(rows[i].cfg_value);
			else send_op(rows[i].op, rows[i].key, rows[i].has_typed, rows[i].typed);
		end

		// Random part in three phases of different table sizes and idling.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_size(8'h81);                 // one bucket, long chains
					send_idle = 6;
					recv_idle = 83;
				end
				1: begin
					write_size(8'($urandom_range(63, 2)));
					send_idle = 83;
					recv_idle = 6;
				end
				default: begin
					write_size(8'd64);                 // pool runs out here
					send_idle = 0;
					recv_idle = 0;
					hold_go <= 1'b1;                   // receiver stalls, core fills up
				end
			endcase
			for (int k = 0; k < N_RANDOM / 3; k++) begin
				op = ($urandom_range(99) < 35) ? OP_INSERT : OP_FIND;
				pick = $urandom_range(99);
				if (pick < 4) key = 64'd0;
				else if (op == OP_FIND && pick < 70 && live_keys.size() != 0)
					key = live_keys[$urandom_range(live_keys.size() - 1)];
				else if (pick < 50) key = 64'($urandom_range(300, 1));
				else key = {$urandom, $urandom};
				send_op(op, key, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d results over sizes 0, 1, 64, 65, 127 and a random size;",
			results_seen);
		$display("%0d nodes allocated, %0d pool-full results, %0d still pending",
			pool_used, pool_full_seen, pending_results.size());
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("chained_hash_set_insert_find_core verification clean");
		end else begin
			$display("chained_hash_set_insert_find_core verification failed");
		end
		$finish;
	end

endmodule
